FILE: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and defaults for the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_DONE
  } mexp_state_t;

endpackage

FILE: rtl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Signed base raised to a signed exponent, reduced by the modulus magnitude.
// ----------------------------------------------------------------------------
// A beat is taken on in_base, in_exponent and in_modulus at a clock edge where
// start is high and busy is low. busy stays high until the cycle in which the
// result beat is shown, so a new beat can be taken at the edge that ends it.
// The result is shown on out_power_residue and out_is_defined for exactly one
// cycle with out_valid high; the receiver cannot stall it.
// A zero modulus or negative exponent gives residue 0 with out_is_defined low.
// Otherwise square-and-multiply runs one exponent step at a time. Each step
// passes through the shared multiplier and then a restoring bit-serial
// remainder unit; an item takes at most 2*DATA_WIDTH-3 steps, and none for
// a zero exponent or an undefined item. The remainder loop sets the rate;
// one item is in flight at a time.
// The remainder keeps the sign of the dividend, so a negative base can give a
// negative residue. A zero exponent returns 1 unreduced.
// Synchronous active-low reset returns the block to idle with no result
// pending; no other state survives between items.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
  parameter int DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_base,
  input  logic signed [DATA_WIDTH-1:0] in_exponent,
  input  logic signed [DATA_WIDTH-1:0] in_modulus,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_power_residue,
  output logic                         out_is_defined
);
  import mexp_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int PW    = 2 * DATA_WIDTH;
  localparam int CNT_W = $clog2(PW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW - 1);

  mexp_state_t state_r, state_nxt;

  logic [W-1:0]     m_r, m_nxt;
  logic [W-1:0]     b_mag_r, b_mag_nxt;
  logic             b_neg_r, b_neg_nxt;
  logic [W-1:0]     acc_mag_r, acc_mag_nxt;
  logic             acc_neg_r, acc_neg_nxt;
  logic [W-1:0]     e_r, e_nxt;
  logic             defined_r, defined_nxt;
  logic             sq_r, sq_nxt;
  logic             neg_r, neg_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_res_r, out_res_nxt;
  logic             out_def_r, out_def_nxt;

  logic             accept;
  logic             in_undef;
  logic [W-1:0]     mod_mag, base_mag;
  logic [W-1:0]     mul_a;
  logic [PW-1:0]    product;
  logic [W:0]       rem_shift;
  logic [W:0]       rem_sub;
  logic [W-1:0]     rem_new;

  assign accept   = start && (state_r == ST_IDLE);
  assign in_undef = (in_modulus == '0) || in_exponent[W-1];
  assign mod_mag  = in_modulus[W-1] ? (~in_modulus + 1'b1) : in_modulus;
  assign base_mag = in_base[W-1] ? (~in_base + 1'b1) : in_base;

  // shared multiplier: square on even exponent, accumulate on odd
  assign mul_a   = e_r[0] ? acc_mag_r : b_mag_r;
  assign product = {{W{1'b0}}, mul_a} * {{W{1'b0}}, b_mag_r};

  // restoring remainder step, one dividend bit per cycle
  assign rem_shift = {rem_r, prod_r[PW-1]};
  assign rem_sub   = rem_shift - {1'b0, m_r};
  assign rem_new   = rem_sub[W] ? rem_shift[W-1:0] : rem_sub[W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        state_nxt = (e_r == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_STEP;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    m_nxt         = m_r;
    b_mag_nxt     = b_mag_r;
    b_neg_nxt     = b_neg_r;
    acc_mag_nxt   = acc_mag_r;
    acc_neg_nxt   = acc_neg_r;
    e_nxt         = e_r;
    defined_nxt   = defined_r;
    sq_nxt        = sq_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    out_def_nxt   = out_def_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          m_nxt     = mod_mag;
          b_mag_nxt = base_mag;
          b_neg_nxt = in_base[W-1];
          // undefined items skip the loop and report zero
          acc_mag_nxt = in_undef ? '0 : W'(1);
          acc_neg_nxt = 1'b0;
          e_nxt       = in_undef ? '0 : in_exponent;
          defined_nxt = !in_undef;
        end
      end
      ST_STEP: begin
        if (e_r != '0) begin
          sq_nxt   = !e_r[0];
          neg_nxt  = e_r[0] && (acc_neg_r ^ b_neg_r);
          prod_nxt = product;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          e_nxt    = e_r[0] ? (e_r - 1'b1) : (e_r >> 1);
        end
      end
      ST_DIV: begin
        prod_nxt = prod_r << 1;
        rem_nxt  = rem_new;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          if (sq_r) begin
            b_mag_nxt = rem_new;
            b_neg_nxt = 1'b0;
          end else begin
            acc_mag_nxt = rem_new;
            acc_neg_nxt = neg_r && (rem_new != '0);
          end
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = acc_neg_r ? (~acc_mag_r + 1'b1) : acc_mag_r;
        out_def_nxt   = defined_r;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    b_mag_r   <= b_mag_nxt;
    b_neg_r   <= b_neg_nxt;
    acc_mag_r <= acc_mag_nxt;
    acc_neg_r <= acc_neg_nxt;
    e_r       <= e_nxt;
    defined_r <= defined_nxt;
    sq_r      <= sq_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    out_res_r <= out_res_nxt;
    out_def_r <= out_def_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_power_residue = out_res_r;
  assign out_is_defined    = out_def_r;

  // a result beat only follows a busy cycle
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding work");

  // results are single-cycle strobes
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // an undefined result reports zero
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_defined) |-> (out_power_residue == '0))
    else $error("undefined result is not zero");

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

endmodule

FILE: dv/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Watches the operand and result channels of the modular exponentiation core.
// Every accepted operand beat is run through a square-and-multiply predictor,
// and the expected residue is queued. Each result beat is compared field by
// field with the oldest queued residue. The failure count and the number of
// residues still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module mexp_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_base,
  input  logic signed [DATA_WIDTH-1:0] in_exponent,
  input  logic signed [DATA_WIDTH-1:0] in_modulus,
  input  logic                         out_valid,
  input  logic signed [DATA_WIDTH-1:0] out_power_residue,
  input  logic                         out_is_defined,
  output int                           fail_count,
  output int                           outstanding
);

  typedef struct {
    logic signed [DATA_WIDTH-1:0] residue;
    logic                         is_defined;
  } residue_t;

  residue_t pending_residues[$];
  int       error_total;

  function automatic bit [63:0] magnitude64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // exact product, remainder truncated toward zero with the dividend's sign
  function automatic longint product_rem(input longint a, input longint b,
                                         input bit [63:0] m);
    bit [63:0] prod;
    prod = (magnitude64(a) * magnitude64(b)) % m;
    return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic residue_t predict_power_residue(input longint b, input longint e,
                                                     input longint m_signed);
    residue_t  r;
    bit [63:0] m;
    longint    acc;
    r.residue    = '0;
    r.is_defined = 1'b0;
    m = magnitude64(m_signed);
    if (m == 0 || e < 0) return r;
    // zero exponent leaves acc at 1, never reduced
    acc = 1;
    while (e > 0) begin
      if (e % 2 == 0) begin
        e = e / 2;
        b = product_rem(b, b, m);
      end else begin
        e = e - 1;
        acc = product_rem(acc, b, m);
      end
    end
    r.residue    = acc[DATA_WIDTH-1:0];
    r.is_defined = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    residue_t expected;
    residue_t predicted;
    if (!rst_n) begin
      pending_residues.delete();
      error_total = 0;
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      // result beat first: a new operand beat may land on the same edge
      if (out_valid) begin
        if (pending_residues.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("unexpected result beat: residue %0d defined %0b",
                     out_power_residue, out_is_defined);
        end else begin
          expected = pending_residues.pop_front();
          if (out_power_residue !== expected.residue ||
              out_is_defined !== expected.is_defined) begin
            error_total++;
            if (error_total <= 10)
              $display("mismatch: residue exp %0d got %0d, defined exp %0b got %0b",
                       expected.residue, out_power_residue,
                       expected.is_defined, out_is_defined);
          end
        end
      end
      if (start && !busy) begin
        predicted = predict_power_residue(in_base, in_exponent, in_modulus);
        pending_residues = {pending_residues, predicted};
      end
      fail_count  <= error_total;
      outstanding <= pending_residues.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the modular exponentiation core.
// A directed set covers zero and negative exponents, zero and most negative
// moduli, negative bases and the field extremes; random operand beats follow,
// with random gaps and gap-free stretches. Checking is done by mexp_checker.
// ----------------------------------------------------------------------------
module tb_top;

  import mexp_pkg::*;

  localparam int DW             = DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 118;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] in_base;
  logic signed [DW-1:0] in_exponent;
  logic signed [DW-1:0] in_modulus;
  logic                 out_valid;
  logic signed [DW-1:0] out_power_residue;
  logic                 out_is_defined;

  int fail_count;
  int outstanding;
  int quiet_cycles;
  bit no_idle_run;

  modular_exponentiation_core #(
    .DATA_WIDTH(DW)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_valid        (out_valid),
    .out_power_residue(out_power_residue),
    .out_is_defined   (out_is_defined)
  );

  mexp_checker #(
    .DATA_WIDTH(DW)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_valid        (out_valid),
    .out_power_residue(out_power_residue),
    .out_is_defined   (out_is_defined),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // counts cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high across back-to-back beats, so it is lowered only for a gap
  task automatic issue_operands(input logic signed [DW-1:0] b,
                                input logic signed [DW-1:0] e,
                                input logic signed [DW-1:0] m);
    int gap;
    gap = no_idle_run ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    in_modulus  <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] edge_or_random();
    case ($urandom_range(0, 5))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return 1;
      4:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] small_modulus();
    logic signed [DW-1:0] m;
    m = $urandom_range(1, 100);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  initial begin
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] e;
    logic signed [DW-1:0] m;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_base      <= '0;
    in_exponent  <= '0;
    in_modulus   <= '0;
    no_idle_run  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero exponent, unreduced even for a unit modulus
    issue_operands(5, 0, 1);
    issue_operands(-9, 0, 7);
    issue_operands(0, 0, 3);
    // undefined: zero modulus, negative exponents
    issue_operands(3, 5, 0);
    issue_operands(3, -1, 7);
    issue_operands(MOST_POS, MOST_NEG, MOST_NEG);
    issue_operands(0, 0, 0);
    // most negative modulus taken as its magnitude
    issue_operands(3, 100, MOST_NEG);
    issue_operands(MOST_NEG, 3, MOST_NEG);
    issue_operands(MOST_NEG + 1, MOST_POS, MOST_NEG);
    // negative bases keep the dividend sign
    issue_operands(-2, 3, 5);
    issue_operands(-3, 2, 7);
    issue_operands(-7, 1, 5);
    issue_operands(MOST_NEG, MOST_POS, MOST_POS);
    issue_operands(MOST_NEG, 1, 3);
    // field extremes and large moduli
    issue_operands(MOST_POS, MOST_POS, MOST_POS);
    issue_operands(MOST_POS - 1, MOST_POS, MOST_POS);
    issue_operands(MOST_POS, MOST_POS, -1);
    issue_operands(2, 10, -1000);
    issue_operands(0, 5, 7);
    issue_operands(32'h12345678, MOST_POS, 32'h7ffffffd);
    issue_operands(-1, MOST_POS, MOST_NEG + 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) no_idle_run = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 99)) inside
        [0:14]: begin
          // undefined beats
          b = $urandom;
          if ($urandom_range(0, 1)) begin
            e = $urandom_range(0, 1000);
            m = '0;
          end else begin
            e = $urandom | MOST_NEG;
            m = $urandom;
          end
        end
        [15:54]: begin
          b = $urandom;
          e = $urandom & MOST_POS;
          m = $urandom;
        end
        [55:84]: begin
          b = $urandom;
          e = $urandom_range(0, 64);
          m = $urandom_range(0, 1) ? small_modulus() : $urandom;
        end
        default: begin
          b = edge_or_random();
          e = edge_or_random();
          m = edge_or_random();
        end
      endcase
      issue_operands(b, e, m);
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: modular_exponentiation_core.f
rtl/mexp_pkg.sv
rtl/modular_exponentiation_core.sv
dv/mexp_checker.sv
dv/tb_top.sv
